// ===== sv/llca_pkg.sv =====
// Types, constants and beat formats shared by the least-loaded channel allocator
package llca_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int LOAD_WIDTH   = 16;
	localparam int OUT_LOAD_W   = 16;
	localparam int ACT_W        = 5;
	localparam int CNT_W        = $clog2(NUM_CHANNELS + 1);
	localparam int IDX_W        = (CNT_W > ACT_W) ? CNT_W : ACT_W;

	typedef logic [LOAD_WIDTH-1:0] load_t;
	typedef logic [IDX_W-1:0]      idx_t;

	localparam load_t LOAD_MAX      = {LOAD_WIDTH{1'b1}};
	localparam idx_t  NUM_IDX       = IDX_W'(NUM_CHANNELS);
	localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(16);

	typedef enum logic {
		OP_ASSIGN  = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SAT   = 2'd1,
		ST_UNDER = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_HOLD
	} state_t;

	typedef struct packed {
		op_t        operation;
		logic [3:0] release_channel;
	} in_beat_t;

	typedef struct packed {
		logic [3:0]            chosen_channel;
		status_t               status;
		logic [OUT_LOAD_W-1:0] new_load;
	} out_beat_t;

	typedef struct packed {
		logic  vld;
		op_t   op;
		idx_t  rel_idx;
		load_t load;
		idx_t  idx;
	} carrier_t;

	typedef struct packed {
		logic en;
		logic inc;
		idx_t idx;
	} upd_t;

endpackage

// ===== sv/llca_cell.sv =====
// One channel cell: holds a load counter and passes the scan carrier on
module llca_cell import llca_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  idx_t     my_idx,
	input  idx_t     active,
	input  carrier_t c_in,
	input  upd_t     upd,
	output carrier_t c_out
);

	load_t    load_q;
	carrier_t c_q;
	carrier_t c_nxt;
	logic     take;

	always_comb begin
		if (c_in.op == OP_ASSIGN) begin
			take = (my_idx < active) && ((my_idx == '0) || (load_q < c_in.load));
		end else begin
			take = (c_in.rel_idx == my_idx);
		end
		c_nxt = c_in;
		if (take) begin
			c_nxt.load = load_q;
			c_nxt.idx  = my_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= '0;
			c_q    <= '0;
		end else begin
			c_q <= c_nxt;
			if (upd.en && (upd.idx == my_idx)) begin
				load_q <= upd.inc ? load_q + load_t'(1) : load_q - load_t'(1);
			end
		end
	end

	assign c_out = c_q;

endmodule

// ===== sv/least_loaded_channel_allocator_top.sv =====
// Least-loaded channel allocator: row of channel cells and its control
//
// Input channel in_valid/in_stall/in_data carries requests: assign the least
// loaded active channel, or release one unit on a named channel. Each request
// gives exactly one result beat on out_valid/out_stall/out_data.
// A request travels as a carrier through the row of NUM_CHANNELS cells, one
// cell per cycle, collecting the minimum load (lowest index on a tie) or the
// named channel's load. The result beat is offered from the output register
// once the carrier leaves the last cell. One request is in the row at a
// time; a new request waits until the last result enters the output register.
// in_stall is high while a request is in the row or its result waits to
// enter the output register. A result held by out_stall does not block the
// next request's walk; the counter update is made when the result enters
// the output register.
// cfg_we/cfg_wdata write active_channels, to be done only while idle.
// Reset clears all counters, sets active_channels to 16 and drops any beat.
module least_loaded_channel_allocator_top import llca_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_beat_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_beat_t        out_data,
	input  logic             cfg_we,
	input  logic [ACT_W-1:0] cfg_wdata
);

	logic [ACT_W-1:0] act_q;
	idx_t             act_ext;
	idx_t             eff_active;
	state_t           state_q, state_nxt;
	carrier_t         chain [NUM_CHANNELS+1];
	carrier_t         hold_q;
	carrier_t         src;
	out_beat_t        out_q, res;
	logic             out_vld_q;
	logic             in_acc, have, fire;
	upd_t             upd;
	idx_t             rel_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			act_q <= cfg_wdata;
		end
	end

	always_comb begin
		act_ext    = IDX_W'(act_q);
		eff_active = act_ext;
		if (act_ext == '0) begin
			eff_active = IDX_W'(1);
		end
		if (act_ext > NUM_IDX) begin
			eff_active = NUM_IDX;
		end
	end

	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	assign chain[0] = '{vld: in_acc, op: in_data.operation,
		rel_idx: IDX_W'(in_data.release_channel), load: '0, idx: '0};

	for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cell
		llca_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.my_idx (IDX_W'(g)),
			.active (eff_active),
			.c_in   (chain[g]),
			.upd    (upd),
			.c_out  (chain[g+1])
		);
	end

	always_comb begin
		src     = (state_q == S_HOLD) ? hold_q : chain[NUM_CHANNELS];
		have    = ((state_q == S_SCAN) && chain[NUM_CHANNELS].vld) || (state_q == S_HOLD);
		fire    = have && (!out_vld_q || !out_stall);
		rel_ext = src.rel_idx;
		res     = '0;
		upd     = '0;
		if (src.op == OP_ASSIGN) begin
			res.chosen_channel = src.idx[3:0];
			if (src.load == LOAD_MAX) begin
				res.status   = ST_SAT;
				res.new_load = OUT_LOAD_W'(src.load);
			end else begin
				res.status   = ST_OK;
				res.new_load = OUT_LOAD_W'(src.load + load_t'(1));
			end
			upd.idx = src.idx;
			upd.inc = 1'b1;
		end else begin
			res.chosen_channel = rel_ext[3:0];
			if (rel_ext >= NUM_IDX) begin
				res.status = ST_RANGE;
			end else if (src.load == '0) begin
				res.status = ST_UNDER;
			end else begin
				res.status   = ST_OK;
				res.new_load = OUT_LOAD_W'(src.load - load_t'(1));
			end
			upd.idx = rel_ext;
			upd.inc = 1'b0;
		end
		upd.en = fire && (res.status == ST_OK);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) state_nxt = S_SCAN;
			end
			S_SCAN: begin
				if (chain[NUM_CHANNELS].vld) state_nxt = fire ? S_IDLE : S_HOLD;
			end
			S_HOLD: begin
				if (fire) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (fire) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
		if ((state_q == S_SCAN) && chain[NUM_CHANNELS].vld) begin
			hold_q <= chain[NUM_CHANNELS];
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

// ===== sv/llca_checker.sv =====
// Port-level checker for the least-loaded channel allocator, with its bind
module llca_checker import llca_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input out_beat_t        out_data,
	input logic             cfg_we
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a request is in the row");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

	a_no_load_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((out_data.status == ST_UNDER) || (out_data.status == ST_RANGE))
		|-> (out_data.new_load == '0))
		else $error("failed release reports a load");

	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_SAT)
		|-> (out_data.new_load == OUT_LOAD_W'(LOAD_MAX)))
		else $error("saturation reported below full count");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !in_stall && !out_valid)
		else $error("register written with a beat in flight");

endmodule

bind least_loaded_channel_allocator_top llca_checker u_llca_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the least-loaded channel allocator
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import llca_pkg::*;

	localparam int CYCLE_LIMIT = 6_000_000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 75;
	localparam int HOLD_CYCLES = 300;

	class load_ledger;
		load_t            chan_load [NUM_CHANNELS];
		logic [ACT_W-1:0] active_reg;
		out_beat_t        awaited_results [$];
		int               errors;

		function new();
			foreach (chan_load[i]) chan_load[i] = '0;
			active_reg = ACTIVE_RESET;
			errors = 0;
		endfunction

		function int span();
			int n;
			n = active_reg;
			if (n == 0) n = 1;
			if (n > NUM_CHANNELS) n = NUM_CHANNELS;
			return n;
		endfunction

		function out_beat_t allocate(in_beat_t req);
			out_beat_t r;
			int best;
			int i;
			int rc;
			best = 0;
			rc = req.release_channel;
			if (req.operation == OP_ASSIGN) begin
				for (i = 1; i < span(); i++)
					if (chan_load[i] < chan_load[best]) best = i;
				r.chosen_channel = 4'(best);
				if (chan_load[best] == LOAD_MAX) begin
					r.status = ST_SAT;
				end else begin
					chan_load[best] = chan_load[best] + 1'b1;
					r.status = ST_OK;
				end
				r.new_load = OUT_LOAD_W'(chan_load[best]);
			end else begin
				r.chosen_channel = req.release_channel;
				if (rc >= NUM_CHANNELS) begin
					r.status   = ST_RANGE;
					r.new_load = '0;
				end else if (chan_load[rc] == '0) begin
					r.status   = ST_UNDER;
					r.new_load = '0;
				end else begin
					chan_load[rc] = chan_load[rc] - 1'b1;
					r.status   = ST_OK;
					r.new_load = OUT_LOAD_W'(chan_load[rc]);
				end
			end
			return r;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function void note_request(in_beat_t req);
			awaited_results = {awaited_results, allocate(req)};
		endfunction

		task check_result(out_beat_t got);
			out_beat_t want;
			if (awaited_results.size() == 0) begin
				report($sformatf("result beat ch %0d with nothing awaited", got.chosen_channel));
			end else begin
				want = awaited_results.pop_front();
				if (got.chosen_channel !== want.chosen_channel)
					report($sformatf("chosen_channel %0d, want %0d",
						got.chosen_channel, want.chosen_channel));
				if (got.status !== want.status)
					report($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.new_load !== want.new_load)
					report($sformatf("new_load %0d, want %0d", got.new_load, want.new_load));
			end
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_beat_t         in_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_beat_t        out_data;
	logic             cfg_we = 1'b0;
	logic [ACT_W-1:0] cfg_wdata = '0;

	load_ledger ledger = new();
	bit         calm = 1'b0;
	bit         hold_req = 1'b0;
	int         cycles = 0;

	least_loaded_channel_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) ledger.note_request(in_data);
		if (arst_n && out_valid && !out_stall) ledger.check_result(out_data);
	end

	initial begin
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	task send_item(op_t op, logic [3:0] ch);
		in_beat_t b;
		b.operation       = op;
		b.release_channel = ch;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		do @(posedge clk); while (in_stall);
	endtask

	task end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task drain();
		while (ledger.awaited_results.size() != 0) @(posedge clk);
		repeat (2 * (NUM_CHANNELS + 1)) @(posedge clk);
	endtask

	task apply_active(logic [ACT_W-1:0] v);
		end_burst();
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		ledger.active_reg = v;
		@(posedge clk);
	endtask

	task random_item();
		int busy [$];
		busy = {};
		if ($urandom_range(0, 99) < 55) begin
			send_item(OP_ASSIGN, 4'($urandom_range(0, 15)));
		end else begin
			foreach (ledger.chan_load[i])
				if (ledger.chan_load[i] != '0) busy = {busy, i};
			if (busy.size() != 0 && $urandom_range(0, 9) < 7)
				send_item(OP_RELEASE, 4'(busy[$urandom_range(0, busy.size() - 1)]));
			else
				send_item(OP_RELEASE, 4'($urandom_range(0, 15)));
		end
	endtask

	initial begin
		logic [ACT_W-1:0] settings [PHASES];
		settings = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd2, 5'd8, 5'd17, 5'd5, 5'd15, 5'd3, 5'd16, 5'd16};
		settings[PHASES - 2] = ACT_W'($urandom_range(0, 31));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_ASSIGN, 4'h0);
		send_item(OP_ASSIGN, 4'hF);
		send_item(OP_ASSIGN, 4'h5);
		send_item(OP_RELEASE, 4'hF);
		send_item(OP_RELEASE, 4'h1);
		send_item(OP_RELEASE, 4'h1);
		send_item(OP_ASSIGN, 4'hA);
		apply_active(5'd0);
		send_item(OP_ASSIGN, 4'h3);
		send_item(OP_RELEASE, 4'h0);
		apply_active(5'd31);
		send_item(OP_ASSIGN, 4'h0);
		apply_active(5'd1);
		send_item(OP_ASSIGN, 4'h0);
		send_item(OP_RELEASE, 4'h2);
		send_item(OP_RELEASE, 4'h9);
		apply_active(5'd2);
		send_item(OP_ASSIGN, 4'h0);
		send_item(OP_ASSIGN, 4'h0);

		for (int p = 0; p < PHASES; p++) begin
			apply_active(settings[p]);
			calm = (p % 4 == 3) || (p == PHASES - 1);
			if (p == 2) hold_req = 1'b1;
			repeat (PHASE_ITEMS) random_item();
		end

		apply_active(5'd1);
		calm = 1'b1;
		send_item(OP_RELEASE, 4'h0);
		send_item(OP_RELEASE, 4'h0);
		send_item(OP_ASSIGN, 4'h0);
		send_item(OP_ASSIGN, 4'h0);
		send_item(OP_ASSIGN, 4'h0);
		end_burst();
		drain();

		if (ledger.errors == 0 && ledger.awaited_results.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
